/* rtl/dsot_pkg.sv */
// shared constants, register codes and helpers for the crystal outline test
`default_nettype none
package dsot_pkg;

	// coordinate width and derived widths
	localparam int COORD_BITS    = 18;
	localparam int SQ_BITS       = 2 * COORD_BITS;
	localparam int FLD_BITS      = 16;
	localparam int DIV_BITS      = 2 * FLD_BITS;
	localparam int NUM_STEPS     = (COORD_BITS > FLD_BITS) ? COORD_BITS : FLD_BITS;
	localparam int VAL_BITS      = ((COORD_BITS > FLD_BITS + 1) ? COORD_BITS : FLD_BITS + 1) + 2;
	localparam int PROD_BITS     = VAL_BITS + FLD_BITS + 1;
	localparam int SUM_BITS      = 2 * VAL_BITS + 1;
	localparam int CFG_DATA_BITS = 48;
	localparam int CFG_IDX_BITS  = 3;

	// configuration register index
	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_OUTER_SIZE     = 3'd0,
		REG_CONTACT_SHAPE  = 3'd1,
		REG_DITCH_SHAPE    = 3'd2,
		REG_HOLE_SHAPE     = 3'd3,
		REG_INNER_TAPER    = 3'd4,
		REG_OUTER_TAPER    = 3'd5,
		REG_EDGE_ROUNDINGS = 3'd6,
		REG_DEAD_LAYER     = 3'd7
	} cfg_reg_t;

	// zero-extend a 16-bit geometry field into the signed working width
	function automatic logic signed [VAL_BITS-1:0] fld_ext(input logic [FLD_BITS-1:0] v);
		return $signed({{(VAL_BITS-FLD_BITS){1'b0}}, v});
	endfunction

endpackage
`default_nettype wire

/* rtl/detector_solid_outside_test_unit.sv */
// crystal outline membership test: pipelined radius, taper divide and shape checks
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------------
//  cfg     | in        | cfg_wen              | cfg_index, cfg_data
//  in      | in        | in_valid / in_ready  | func, x_pos, y_pos, z_pos, radial_pos
//  out     | out       | out_valid / out_ready| is_outside
//
// one item enters per cycle while the output is not stalled; the pipeline depth is set by the
// bit-per-stage square root, and the top taper divide runs beside it in fewer stages.
// the whole pipeline advances when the output register is empty or being taken,
// so a stalled output freezes every stage in place and in_ready follows it.
// asynchronous reset clears all valid bits and the configuration registers.
`default_nettype none
module detector_solid_outside_test_unit
	import dsot_pkg::*;
(
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wen,
	input  logic [CFG_IDX_BITS-1:0]        cfg_index,
	input  logic [CFG_DATA_BITS-1:0]       cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           func,
	input  logic signed [COORD_BITS-1:0]   x_pos,
	input  logic signed [COORD_BITS-1:0]   y_pos,
	input  logic signed [COORD_BITS-1:0]   z_pos,
	input  logic signed [COORD_BITS-1:0]   radial_pos,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           is_outside
);

	// configuration registers
	logic [31:0] outer_size_q;
	logic [32:0] contact_shape_q;
	logic [47:0] ditch_shape_q;
	logic [47:0] hole_shape_q;
	logic [31:0] inner_taper_q;
	logic [31:0] outer_taper_q;
	logic [47:0] edge_roundings_q;
	logic [15:0] dead_layer_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outer_size_q     <= '0;
			contact_shape_q  <= '0;
			ditch_shape_q    <= '0;
			hole_shape_q     <= '0;
			inner_taper_q    <= '0;
			outer_taper_q    <= '0;
			edge_roundings_q <= '0;
			dead_layer_q     <= '0;
		end else if (cfg_wen) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_OUTER_SIZE:     outer_size_q     <= cfg_data[31:0];
				REG_CONTACT_SHAPE:  contact_shape_q  <= cfg_data[32:0];
				REG_DITCH_SHAPE:    ditch_shape_q    <= cfg_data[47:0];
				REG_HOLE_SHAPE:     hole_shape_q     <= cfg_data[47:0];
				REG_INNER_TAPER:    inner_taper_q    <= cfg_data[31:0];
				REG_OUTER_TAPER:    outer_taper_q    <= cfg_data[31:0];
				REG_EDGE_ROUNDINGS: edge_roundings_q <= cfg_data[47:0];
				REG_DEAD_LAYER:     dead_layer_q     <= cfg_data[15:0];
				default:            dead_layer_q     <= dead_layer_q;
			endcase
		end
	end

	// geometry fields
	logic [FLD_BITS-1:0] otl, otw, tbr;
	logic signed [VAL_BITS-1:0] zmax_v, rmax_v, pcl_v, pcr_v, dd_v, dt_v, wr_v;
	logic signed [VAL_BITS-1:0] hr_v, hl_v, hb_v, itl_v, itw_v, otl_v, otw_v;
	logic signed [VAL_BITS-1:0] tbr_v, bbr_v, btl_v, li_v;

	assign otl    = outer_taper_q[31:16];
	assign otw    = outer_taper_q[15:0];
	assign tbr    = edge_roundings_q[47:32];
	assign zmax_v = fld_ext(outer_size_q[31:16]);
	assign rmax_v = fld_ext(outer_size_q[15:0]);
	assign pcl_v  = fld_ext(contact_shape_q[31:16]);
	assign pcr_v  = fld_ext(contact_shape_q[15:0]);
	assign dd_v   = fld_ext(ditch_shape_q[47:32]);
	assign dt_v   = fld_ext(ditch_shape_q[31:16]);
	assign wr_v   = fld_ext(ditch_shape_q[15:0]);
	assign hr_v   = fld_ext(hole_shape_q[47:32]);
	assign hl_v   = fld_ext(hole_shape_q[31:16]);
	assign hb_v   = fld_ext(hole_shape_q[15:0]);
	assign itl_v  = fld_ext(inner_taper_q[31:16]);
	assign itw_v  = fld_ext(inner_taper_q[15:0]);
	assign otl_v  = fld_ext(otl);
	assign otw_v  = fld_ext(otw);
	assign tbr_v  = fld_ext(tbr);
	assign bbr_v  = fld_ext(edge_roundings_q[31:16]);
	assign btl_v  = fld_ext(edge_roundings_q[15:0]);
	assign li_v   = fld_ext(dead_layer_q);

	// global advance: output register empty or taken
	logic adv;
	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	// stage registers
	logic vld_s1, vld_s2, vld_s4, vld_s5, vld_s6;
	logic [NUM_STEPS:0] stp_vld_s;

	logic                         func_s1;
	logic signed [COORD_BITS-1:0] x_s1, y_s1, z_s1, rad_s1;

	logic                         cyl_s2;
	logic [SQ_BITS-1:0]           xx_s2, yy_s2;
	logic signed [COORD_BITS-1:0] z_s2;
	logic [COORD_BITS-1:0]        rc_s2;
	logic [DIV_BITS-1:0]          dnum_s2;

	logic [SQ_BITS-1:0]           stp_rem_s  [NUM_STEPS+1];
	logic [COORD_BITS-1:0]        stp_root_s [NUM_STEPS+1];
	logic [DIV_BITS-1:0]          stp_drem_s [NUM_STEPS+1];
	logic [FLD_BITS-1:0]          stp_dq_s   [NUM_STEPS+1];
	logic signed [COORD_BITS-1:0] stp_z_s    [NUM_STEPS+1];
	logic [COORD_BITS-1:0]        stp_rc_s   [NUM_STEPS+1];
	logic                         stp_cyl_s  [NUM_STEPS+1];

	logic [SQ_BITS-1:0]    nx_rem  [NUM_STEPS];
	logic [COORD_BITS-1:0] nx_root [NUM_STEPS];
	logic [DIV_BITS-1:0]   nx_drem [NUM_STEPS];
	logic [FLD_BITS-1:0]   nx_dq   [NUM_STEPS];

	// squares, radial position magnitude and top taper numerator
	logic signed [SQ_BITS-1:0]   xsq, ysq;
	logic [COORD_BITS-1:0]       rabs;
	logic [DIV_BITS-1:0]         dnum;

	always_comb begin
		xsq  = SQ_BITS'(x_s1) * SQ_BITS'(x_s1);
		ysq  = SQ_BITS'(y_s1) * SQ_BITS'(y_s1);
		rabs = rad_s1[COORD_BITS-1] ? COORD_BITS'(-rad_s1) : COORD_BITS'(rad_s1);
		dnum = '0;
		if (otl > tbr)
			dnum = DIV_BITS'(otl - tbr) * DIV_BITS'(otw);
	end

	// one square root bit per stage, and one quotient bit in each of the first FLD_BITS stages
	always_comb begin
		logic [SQ_BITS:0]    trial;
		logic [DIV_BITS-1:0] dtrial;
		trial  = '0;
		dtrial = '0;
		for (int j = 0; j < NUM_STEPS; j++) begin
			nx_rem[j]  = stp_rem_s[j];
			nx_root[j] = stp_root_s[j];
			nx_drem[j] = stp_drem_s[j];
			nx_dq[j]   = stp_dq_s[j];
			if (j < COORD_BITS) begin
				trial = ((SQ_BITS+1)'(stp_root_s[j]) << (COORD_BITS - j))
					+ ((SQ_BITS+1)'(1) << (2 * (COORD_BITS - 1 - j)));
				if ({1'b0, stp_rem_s[j]} >= trial) begin
					nx_rem[j]  = stp_rem_s[j] - trial[SQ_BITS-1:0];
					nx_root[j] = stp_root_s[j] | (COORD_BITS'(1) << (COORD_BITS - 1 - j));
				end
			end
			if (j < FLD_BITS) begin
				// a zero-length taper leaves the quotient at zero
				dtrial = DIV_BITS'(otl) << (FLD_BITS - 1 - j);
				if ((otl != '0) && (stp_drem_s[j] >= dtrial)) begin
					nx_drem[j] = stp_drem_s[j] - dtrial;
					nx_dq[j]   = stp_dq_s[j] | (FLD_BITS'(1) << (FLD_BITS - 1 - j));
				end
			end
		end
	end

	// shape guards and differences from radius and height
	logic signed [VAL_BITS-1:0] rv, zv, r1, z1, hend, ah, at, la, pcdiff;
	logic                       pclong;
	logic                       ob_n, pcin_n, pclt_n, ditch_n, holein_n, holelt_n;
	logic                       itin_n, otin_n, bt_n, topin_n, botin_n;
	logic signed [VAL_BITS-1:0] pca_n, pcb_n, ha_n, hb2_n, itk_n, itn_n, otk_n, otn_n;
	logic signed [VAL_BITS-1:0] ta_n, tb_n, ba_n, bb_n;
	logic [FLD_BITS-1:0]        pclim_n;

	always_comb begin
		rv     = stp_cyl_s[NUM_STEPS] ? $signed(VAL_BITS'(stp_rc_s[NUM_STEPS]))
			: $signed(VAL_BITS'(stp_root_s[NUM_STEPS]));
		zv     = VAL_BITS'(stp_z_s[NUM_STEPS]);
		r1     = rmax_v - rv;
		z1     = zmax_v - zv;
		ob_n   = (zv > zmax_v) || zv[VAL_BITS-1] || (rv > rmax_v);
		// point contact
		pcin_n  = (zv < pcl_v) && (rv < pcr_v);
		pclong  = pcl_v > pcr_v;
		pcdiff  = pclong ? (pcl_v - pcr_v) : (pcr_v - pcl_v);
		pclt_n  = pclong ? (zv < pcdiff) : (rv < pcdiff);
		pca_n   = pclong ? (zv - pcdiff) : zv;
		pcb_n   = pclong ? rv : (rv - pcdiff);
		pclim_n = pclong ? contact_shape_q[15:0] : contact_shape_q[31:16];
		// ditch, inclusive depth in cylindrical mode
		ditch_n = (stp_cyl_s[NUM_STEPS] ? (zv <= dd_v) : (zv < dd_v))
			&& (dt_v != '0) && (wr_v != '0) && (rv < wr_v) && (rv > wr_v - dt_v);
		// bore hole with rounded end
		hend     = zmax_v - hl_v + hb_v;
		ah       = hr_v - hb_v;
		holein_n = (rv < hr_v) && (z1 < hl_v);
		holelt_n = (zv > hend) || (rv < ah);
		ha_n     = hend - zv;
		hb2_n    = rv - ah;
		// inner and outer tapers as cross-multiplied compares
		itin_n = z1 < itl_v;
		itk_n  = rv - hr_v + VAL_BITS'(1);
		itn_n  = itl_v - z1;
		otin_n = z1 < otl_v;
		otk_n  = r1 + VAL_BITS'(1);
		otn_n  = otl_v - z1;
		// bottom 45-degree taper
		bt_n = (zv < btl_v) && (r1 < btl_v - zv);
		// top edge rounding, offset by the taper quotient
		at      = fld_ext(stp_dq_s[NUM_STEPS]);
		topin_n = (z1 < tbr_v) && (r1 < tbr_v + at);
		ta_n    = tbr_v - r1 + at;
		tb_n    = tbr_v - z1;
		// bottom edge rounding, raised by the lithium layer in cylindrical mode
		la      = stp_cyl_s[NUM_STEPS] ? li_v : '0;
		botin_n = (zv < bbr_v + la) && (r1 < bbr_v);
		ba_n    = bbr_v - r1;
		bb_n    = bbr_v - zv + la;
	end

	logic                       ob_s4, pcin_s4, pcround_s4, pclt_s4, ditch_s4, holein_s4;
	logic                       holelt_s4, itin_s4, otin_s4, bt_s4, topin_s4, botin_s4;
	logic signed [VAL_BITS-1:0] pca_s4, pcb_s4, ha_s4, hb2_s4, itk_s4, itn_s4, otk_s4;
	logic signed [VAL_BITS-1:0] otn_s4, ta_s4, tb_s4, ba_s4, bb_s4;
	logic [FLD_BITS-1:0]        pclim_s4;

	logic                        ob_s5, pcin_s5, pcround_s5, pclt_s5, ditch_s5, holein_s5;
	logic                        holelt_s5, itin_s5, otin_s5, bt_s5, topin_s5, botin_s5;
	logic signed [SUM_BITS-1:0]  pcsq_s5, holesq_s5, topsq_s5, botsq_s5;
	logic [DIV_BITS-1:0]         pclimsq_s5, hbsq_s5, tbsq_s5, bbsq_s5;
	logic signed [PROD_BITS-1:0] itm_s5, itn_s5, otm_s5, otn_s5;

	logic res_s6;

	// final decision: bounds first, then the point contact region, else all other cuts
	logic pccut, restcut, res_n;
	always_comb begin
		pccut   = !pcround_s5 || pclt_s5
			|| (pcsq_s5 < $signed(SUM_BITS'(pclimsq_s5)));
		restcut = ditch_s5
			|| (holein_s5 && (holelt_s5 || (holesq_s5 < $signed(SUM_BITS'(hbsq_s5)))))
			|| (itin_s5 && (itm_s5 <= itn_s5))
			|| (otin_s5 && (otm_s5 <= otn_s5))
			|| bt_s5
			|| (topin_s5 && (topsq_s5 > $signed(SUM_BITS'(tbsq_s5))))
			|| (botin_s5 && (botsq_s5 > $signed(SUM_BITS'(bbsq_s5))));
		res_n   = ob_s5 || (pcin_s5 ? pccut : restcut);
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			stp_vld_s <= '0;
			vld_s4    <= 1'b0;
			vld_s5    <= 1'b0;
			vld_s6    <= 1'b0;
		end else if (adv) begin
			vld_s1    <= in_valid;
			vld_s2    <= vld_s1;
			stp_vld_s <= {stp_vld_s[NUM_STEPS-1:0], vld_s2};
			vld_s4    <= stp_vld_s[NUM_STEPS];
			vld_s5    <= vld_s4;
			vld_s6    <= vld_s5;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (adv) begin
			func_s1 <= func;
			x_s1    <= x_pos;
			y_s1    <= y_pos;
			z_s1    <= z_pos;
			rad_s1  <= radial_pos;

			cyl_s2  <= func_s1;
			xx_s2   <= xsq;
			yy_s2   <= ysq;
			z_s2    <= z_s1;
			rc_s2   <= rabs;
			dnum_s2 <= dnum;

			stp_rem_s[0]  <= xx_s2 + yy_s2;
			stp_root_s[0] <= '0;
			stp_drem_s[0] <= dnum_s2;
			stp_dq_s[0]   <= '0;
			stp_z_s[0]    <= z_s2;
			stp_rc_s[0]   <= rc_s2;
			stp_cyl_s[0]  <= cyl_s2;
			for (int j = 0; j < NUM_STEPS; j++) begin
				stp_rem_s[j+1]  <= nx_rem[j];
				stp_root_s[j+1] <= nx_root[j];
				stp_drem_s[j+1] <= nx_drem[j];
				stp_dq_s[j+1]   <= nx_dq[j];
				stp_z_s[j+1]    <= stp_z_s[j];
				stp_rc_s[j+1]   <= stp_rc_s[j];
				stp_cyl_s[j+1]  <= stp_cyl_s[j];
			end

			ob_s4      <= ob_n;
			pcin_s4    <= pcin_n;
			pcround_s4 <= contact_shape_q[32];
			pclt_s4    <= pclt_n;
			pca_s4     <= pca_n;
			pcb_s4     <= pcb_n;
			pclim_s4   <= pclim_n;
			ditch_s4   <= ditch_n;
			holein_s4  <= holein_n;
			holelt_s4  <= holelt_n;
			ha_s4      <= ha_n;
			hb2_s4     <= hb2_n;
			itin_s4    <= itin_n;
			itk_s4     <= itk_n;
			itn_s4     <= itn_n;
			otin_s4    <= otin_n;
			otk_s4     <= otk_n;
			otn_s4     <= otn_n;
			bt_s4      <= bt_n;
			topin_s4   <= topin_n;
			ta_s4      <= ta_n;
			tb_s4      <= tb_n;
			botin_s4   <= botin_n;
			ba_s4      <= ba_n;
			bb_s4      <= bb_n;

			ob_s5      <= ob_s4;
			pcin_s5    <= pcin_s4;
			pcround_s5 <= pcround_s4;
			pclt_s5    <= pclt_s4;
			pcsq_s5    <= SUM_BITS'(pca_s4) * SUM_BITS'(pca_s4)
				+ SUM_BITS'(pcb_s4) * SUM_BITS'(pcb_s4);
			pclimsq_s5 <= DIV_BITS'(pclim_s4) * DIV_BITS'(pclim_s4);
			ditch_s5   <= ditch_s4;
			holein_s5  <= holein_s4;
			holelt_s5  <= holelt_s4;
			holesq_s5  <= SUM_BITS'(ha_s4) * SUM_BITS'(ha_s4)
				+ SUM_BITS'(hb2_s4) * SUM_BITS'(hb2_s4);
			hbsq_s5    <= DIV_BITS'(hole_shape_q[15:0]) * DIV_BITS'(hole_shape_q[15:0]);
			itin_s5    <= itin_s4;
			itm_s5     <= PROD_BITS'(itk_s4) * PROD_BITS'(itl_v);
			itn_s5     <= PROD_BITS'(itn_s4) * PROD_BITS'(itw_v);
			otin_s5    <= otin_s4;
			otm_s5     <= PROD_BITS'(otk_s4) * PROD_BITS'(otl_v);
			otn_s5     <= PROD_BITS'(otn_s4) * PROD_BITS'(otw_v);
			bt_s5      <= bt_s4;
			topin_s5   <= topin_s4;
			topsq_s5   <= SUM_BITS'(ta_s4) * SUM_BITS'(ta_s4)
				+ SUM_BITS'(tb_s4) * SUM_BITS'(tb_s4);
			tbsq_s5    <= DIV_BITS'(tbr) * DIV_BITS'(tbr);
			botin_s5   <= botin_s4;
			botsq_s5   <= SUM_BITS'(ba_s4) * SUM_BITS'(ba_s4)
				+ SUM_BITS'(bb_s4) * SUM_BITS'(bb_s4);
			bbsq_s5    <= DIV_BITS'(edge_roundings_q[31:16])
				* DIV_BITS'(edge_roundings_q[31:16]);

			res_s6 <= res_n;
		end
	end

	assign out_valid  = vld_s6;
	assign is_outside = res_s6;

	// an accepted item occupies the first stage next cycle
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> vld_s1)
		else $error("accepted item missing from first stage");

	// a stall freezes every valid bit in the pipe
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable({vld_s1, vld_s2, stp_vld_s, vld_s4, vld_s5, vld_s6}))
		else $error("pipeline moved during stall");

	// a point beyond the outer bounds always reports outside
	a_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && vld_s5 && ob_s5) |=> (out_valid && is_outside))
		else $error("out-of-bounds point reported inside");

	// a valid result must have come through the last shape stage
	a_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(vld_s5))
		else $error("result without a source item");

endmodule
`default_nettype wire

/* dv/detector_solid_outside_test_unit_tb.sv */
// testbench for the crystal outline test: self-checking with an inline geometry predictor
`default_nettype none
module detector_solid_outside_test_unit_tb;
	import dsot_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	// answer store and comparison
	class outside_scoreboard;
		bit expected_q[$];
		int errors;

		function void note_point(bit ans);
			expected_q.push_back(ans);
		endfunction

		function void check_answer(bit got);
			bit want;
			if (expected_q.size() == 0) begin
				report_mismatch($sformatf("unexpected item is_outside=%0b", got));
				return;
			end
			want = expected_q.pop_front();
			if (got !== want)
				report_mismatch($sformatf("is_outside got %0b want %0b", got, want));
		endfunction

		function void report_mismatch(string msg);
			errors++;
			if (errors <= 40)
				$display("mismatch: %s", msg);
		endfunction
	endclass

	logic clk, arst_n;
	logic cfg_wen;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_data;
	logic in_valid, in_ready, func;
	logic signed [COORD_BITS-1:0] x_pos, y_pos, z_pos, radial_pos;
	logic out_valid, out_ready, is_outside;

	detector_solid_outside_test_unit dut (.*);

	outside_scoreboard sb = new();
	int send_idle, recv_idle;
	int quiet_cycles;
	bit done;

	// geometry shadow
	logic [47:0] geo [0:7];

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	function automatic longint f16(logic [47:0] w, int lo);
		return longint'((w >> lo) & 48'hFFFF);
	endfunction

	function automatic longint root_floor(longint n);
		longint res, bitv;
		res = 0;
		bitv = 64'sd1 << 62;
		while (bitv > n) bitv >>= 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n -= res + bitv;
				res = (res >> 1) + bitv;
			end else res >>= 1;
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic bit predict_outside(bit cyl, longint r, longint z);
		longint zmax, rmax, pcl, pcr, dd, dt, wr, hr, hl, hb, itl, itw, otl, otw;
		longint tbr, bbr, btl, li, r1, z1, a, b;
		bit rpc;
		zmax = f16(geo[REG_OUTER_SIZE], 16); rmax = f16(geo[REG_OUTER_SIZE], 0);
		pcl = f16(geo[REG_CONTACT_SHAPE], 16); pcr = f16(geo[REG_CONTACT_SHAPE], 0);
		rpc = geo[REG_CONTACT_SHAPE][32];
		dd = f16(geo[REG_DITCH_SHAPE], 32); dt = f16(geo[REG_DITCH_SHAPE], 16);
		wr = f16(geo[REG_DITCH_SHAPE], 0);
		hr = f16(geo[REG_HOLE_SHAPE], 32); hl = f16(geo[REG_HOLE_SHAPE], 16);
		hb = f16(geo[REG_HOLE_SHAPE], 0);
		itl = f16(geo[REG_INNER_TAPER], 16); itw = f16(geo[REG_INNER_TAPER], 0);
		otl = f16(geo[REG_OUTER_TAPER], 16); otw = f16(geo[REG_OUTER_TAPER], 0);
		tbr = f16(geo[REG_EDGE_ROUNDINGS], 32); bbr = f16(geo[REG_EDGE_ROUNDINGS], 16);
		btl = f16(geo[REG_EDGE_ROUNDINGS], 0);
		li = f16(geo[REG_DEAD_LAYER], 0);
		if (z > zmax || z < 0 || r > rmax) return 1;
		r1 = rmax - r;
		z1 = zmax - z;
		// point contact pocket
		if (z < pcl && r < pcr) begin
			if (!rpc) return 1;
			if (pcl > pcr) begin
				a = pcl - pcr;
				if (z < a || (z - a) * (z - a) + r * r < pcr * pcr) return 1;
			end else begin
				a = pcr - pcl;
				if (r < a || z * z + (r - a) * (r - a) < pcl * pcl) return 1;
			end
			return 0;
		end
		// ditch
		if ((cyl ? (z <= dd) : (z < dd)) && dt > 0 && wr > 0 && r < wr && r > wr - dt)
			return 1;
		// bore hole with rounded end
		if (r < hr && z1 < hl) begin
			b = zmax - hl + hb;
			if (z > b) return 1;
			a = hr - hb;
			if (r < a || (b - z) * (b - z) + (r - a) * (r - a) < hb * hb) return 1;
		end
		// tapers
		if (z1 < itl && r < hr + ((itl - z1) * itw) / itl) return 1;
		if (z1 < otl && r1 < ((otl - z1) * otw) / otl) return 1;
		if (z < btl && r1 < btl - z) return 1;
		// edge roundings
		a = 0;
		if (otl > tbr) a = ((otl - tbr) * otw) / otl;
		if (z1 < tbr && r1 < tbr + a &&
				(tbr - r1 + a) * (tbr - r1 + a) + (tbr - z1) * (tbr - z1) > tbr * tbr)
			return 1;
		a = cyl ? li : 0;
		if (z < bbr + a && r1 < bbr &&
				(bbr - r1) * (bbr - r1) + (bbr - z + a) * (bbr - z + a) > bbr * bbr)
			return 1;
		return 0;
	endfunction

	function automatic bit predict_point(bit f, logic signed [COORD_BITS-1:0] x,
			logic signed [COORD_BITS-1:0] y, logic signed [COORD_BITS-1:0] z,
			logic signed [COORD_BITS-1:0] rp);
		longint r, xs, ys;
		if (f) begin
			r = longint'(rp);
			if (r < 0) r = -r;
		end else begin
			xs = longint'(x);
			ys = longint'(y);
			r = root_floor(xs * xs + ys * ys);
		end
		return predict_outside(f, r, longint'(z));
	endfunction

	// result side
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_answer(is_outside);
		if (recv_idle > 0)
			out_ready <= ($urandom_range(99) >= recv_idle);
		else
			out_ready <= 1'b1;
	end

	// watchdog on accept activity
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 3000 && !done) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic write_reg(cfg_reg_t idx, logic [47:0] val);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_wen <= 1'b0;
		case (idx)
			REG_OUTER_SIZE, REG_INNER_TAPER, REG_OUTER_TAPER: geo[idx] = val & 48'hFFFFFFFF;
			REG_CONTACT_SHAPE: geo[idx] = val & 48'h1FFFFFFFF;
			REG_DEAD_LAYER: geo[idx] = val & 48'hFFFF;
			default: geo[idx] = val;
		endcase
	endtask

	task automatic send_point(bit f, logic signed [COORD_BITS-1:0] x,
			logic signed [COORD_BITS-1:0] y, logic signed [COORD_BITS-1:0] z,
			logic signed [COORD_BITS-1:0] rp);
		while (send_idle > 0 && $urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		x_pos <= x;
		y_pos <= y;
		z_pos <= z;
		radial_pos <= rp;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_point(predict_point(f, x, y, z, rp));
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	// random field in 1/256 mm, mostly small, sometimes full range
	function automatic logic [15:0] rfld(int hi);
		return ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(hi));
	endfunction

	task automatic random_geometry;
		logic [15:0] h, rr;
		h = rfld(20000);
		rr = rfld(10000);
		write_reg(REG_OUTER_SIZE, {h, rr});
		write_reg(REG_CONTACT_SHAPE, {1'($urandom), rfld(800), rfld(1000)});
		write_reg(REG_DITCH_SHAPE, {rfld(1000), rfld(1000), rfld(6000)});
		write_reg(REG_HOLE_SHAPE, {rfld(3000), rfld(12000), rfld(2000)});
		write_reg(REG_INNER_TAPER, {rfld(6000), rfld(1500)});
		write_reg(REG_OUTER_TAPER, {rfld(6000), rfld(2500)});
		write_reg(REG_EDGE_ROUNDINGS, {rfld(2000), rfld(2000), rfld(2000)});
		write_reg(REG_DEAD_LAYER, 48'(rfld(500)));
	endtask

	function automatic logic signed [COORD_BITS-1:0] rcoord(int span);
		if ($urandom_range(15) == 0)
			return COORD_BITS'($urandom);
		return COORD_BITS'($signed($urandom_range(2 * span)) - span);
	endfunction

	task automatic random_points(int n);
		int span;
		logic signed [COORD_BITS-1:0] zz;
		span = int'(f16(geo[REG_OUTER_SIZE], 0)) + 200;
		for (int i = 0; i < n; i++) begin
			zz = COORD_BITS'($signed($urandom_range(f16(geo[REG_OUTER_SIZE], 16) + 400)) - 200);
			if ($urandom_range(15) == 0) zz = COORD_BITS'($urandom);
			send_point(1'($urandom), rcoord(span), rcoord(span), zz, rcoord(span));
		end
	endtask

	localparam logic signed [COORD_BITS-1:0] CMAX = {1'b0, {(COORD_BITS-1){1'b1}}};
	localparam logic signed [COORD_BITS-1:0] CMIN = {1'b1, {(COORD_BITS-1){1'b0}}};

	initial begin
		arst_n = 0;
		cfg_wen = 0; cfg_index = '0; cfg_data = '0;
		in_valid = 0; func = 0; x_pos = '0; y_pos = '0; z_pos = '0; radial_pos = '0;
		out_ready = 0;
		send_idle = 0; recv_idle = 0; done = 0;
		for (int i = 0; i < 8; i++) geo[i] = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// all-zero geometry then extreme coordinates
		send_point(0, '0, '0, '0, '0);
		send_point(1, '0, '0, '0, CMIN);
		send_point(0, CMAX, CMAX, CMAX, '0);
		send_point(0, CMIN, CMIN, '0, CMAX);
		drain();

		// a typical crystal with every feature, rounded contact
		write_reg(REG_OUTER_SIZE, {16'd7680, 16'd9000});
		write_reg(REG_CONTACT_SHAPE, {1'b1, 16'd500, 16'd300});
		write_reg(REG_DITCH_SHAPE, {16'd500, 16'd600, 16'd4000});
		write_reg(REG_HOLE_SHAPE, {16'd1500, 16'd4000, 16'd1200});
		write_reg(REG_INNER_TAPER, {16'd1000, 16'd500});
		write_reg(REG_OUTER_TAPER, {16'd1500, 16'd1200});
		write_reg(REG_EDGE_ROUNDINGS, {16'd800, 16'd700, 16'd400});
		write_reg(REG_DEAD_LAYER, 48'd300);
		send_point(1, '0, '0, 18'sd100, 18'sd100);  // inside contact pocket
		send_point(1, '0, '0, 18'sd450, 18'sd250);  // contact rounding
		send_point(0, 18'sd3700, '0, 18'sd500, '0);  // ditch depth, cartesian
		send_point(1, '0, '0, 18'sd500, 18'sd3700);  // ditch depth, cylindrical
		send_point(1, '0, '0, 18'sd5000, 18'sd500);  // bore hole
		send_point(1, '0, '0, 18'sd3800, 18'sd1000); // hole end rounding
		send_point(1, '0, '0, 18'sd7600, 18'sd1700); // inner taper
		send_point(1, '0, '0, 18'sd7600, 18'sd8800); // outer taper
		send_point(1, '0, '0, 18'sd100, 18'sd8800);  // bottom taper
		send_point(0, 18'sd6000, 18'sd6000, 18'sd200, '0);
		send_point(1, '0, '0, 18'sd800, 18'sd8700);  // bottom rounding + dead layer
		send_point(0, '0, '0, 18'sd800, '0);
		send_point(1, '0, '0, 18'sd7681, 18'sd10);
		send_point(1, '0, '0, -18'sd1, 18'sd10);
		drain();
		write_reg(REG_CONTACT_SHAPE, {1'b1, 16'd300, 16'd500});
		send_point(1, '0, '0, 18'sd250, 18'sd450);
		send_point(1, '0, '0, 18'sd100, 18'sd100);
		drain();
		// all-ones geometry
		for (int i = 0; i < 8; i++) write_reg(cfg_reg_t'(i), '1);
		send_point(0, CMAX, CMIN, CMAX, '0);
		send_point(1, '0, '0, 18'sd1000, CMAX);
		drain();

		// random phases: geometry between, idling varied
		for (int ph = 0; ph < 16; ph++) begin
			case (ph % 4)
				0: begin send_idle = 0; recv_idle = 0; end
				1: begin send_idle = 68; recv_idle = 0; end
				2: begin send_idle = 0; recv_idle = 68; end
				default: begin send_idle = 22; recv_idle = 22; end
			endcase
			random_geometry();
			random_points(75);
			drain();
		end
		done = 1;
		if (sb.errors == 0 && sb.expected_q.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
`default_nettype wire
